// ----- hw/rtl/pct_pkg.sv -----
package pct_pkg;

   typedef enum logic [1:0] {
      FN_APPEND_FIRST  = 2'd0,
      FN_APPEND_SECOND = 2'd1,
      FN_RUN_TEST      = 2'd2,
      FN_CLEAR         = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STREAM,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // load shift into the cell row: shift strobe and segment-present flag
   typedef struct packed {
      logic shift;
      logic active;
   } load_ctl_type;

endpackage

// ----- hw/rtl/polyline_crossing_test.sv -----
// Append and clear requests: taken one per cycle while no test is running, no response.
// Test request: one response, after B = ceil((first_count-1)/NUM_CELLS) batches of
// load, stream and drain; with no batch when a polyline has fewer than two points.
// The row of NUM_CELLS cells holds a batch of first-polyline segments while the
// second polyline streams past it one segment per cycle from its store's read port.
// Reset (synchronous): both stores empty, dropped-point flag clear, no response pending.
module polyline_crossing_test #(
   parameter int unsigned MAX_POINTS = 256,
   parameter int unsigned COORD_BITS = 13,
   parameter int unsigned NUM_CELLS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_crossing_found,
   output logic                         rsp_points_dropped
);

   localparam int unsigned AW           = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CW           = $clog2(MAX_POINTS + 1);
   localparam int unsigned NW           = $clog2(MAX_POINTS + NUM_CELLS + 8);
   localparam int unsigned XW           = NW + 1;
   localparam int unsigned PTW          = 2 * COORD_BITS;
   localparam int unsigned DRAIN_CYCLES = NUM_CELLS + 3;

   pct_pkg::state_type state_ff, state_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [XW-1:0]      base_ff, base_in;
   logic               hit_ff, hit_in;
   logic [CW-1:0]      fcount_ff, fcount_in;
   logic [CW-1:0]      scount_ff, scount_in;
   logic               overflow_ff, overflow_in;
   logic               ld_vld_ff, ld_vld_in;
   logic               ld_first_ff, ld_first_in;
   logic               ld_act_ff, ld_act_in;
   logic               st_vld_ff, st_vld_in;
   logic               st_first_ff, st_first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic [PTW-1:0]     first_mem  [MAX_POINTS];
   logic [PTW-1:0]     second_mem [MAX_POINTS];
   logic [PTW-1:0]     frd_ff, fprev_ff;
   logic [PTW-1:0]     srd_ff, sprev_ff;
   logic               fwr_en, swr_en;
   logic [AW-1:0]      frd_addr, srd_addr;

   logic               req_accept;
   logic [XW-1:0]      ld_idx;
   logic [XW-1:0]      next_base;

   pct_pkg::load_ctl_type    chain_ld_ctl;
   logic                     chain_st_valid;
   logic                     chain_hit;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      hit_in       = hit_ff || chain_hit;
      fcount_in    = fcount_ff;
      scount_in    = scount_ff;
      overflow_in  = overflow_ff;
      ld_vld_in    = 1'b0;
      ld_first_in  = 1'b0;
      ld_act_in    = 1'b0;
      st_vld_in    = 1'b0;
      st_first_in  = 1'b0;
      fwr_en       = 1'b0;
      swr_en       = 1'b0;
      frd_addr     = '0;
      srd_addr     = '0;
      ld_idx       = base_ff + XW'(cnt_ff);
      next_base    = base_ff + XW'(NUM_CELLS);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_drop_in  = rsp_drop_ff;

      req_stall  = (state_ff != pct_pkg::ST_IDLE);
      req_accept = req_valid && !req_stall;

      case (state_ff)
         pct_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (pct_pkg::func_type'(req_func))
                  pct_pkg::FN_APPEND_FIRST: begin
                     if (fcount_ff < CW'(MAX_POINTS)) begin
                        fwr_en    = 1'b1;
                        fcount_in = fcount_ff + CW'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  pct_pkg::FN_APPEND_SECOND: begin
                     if (scount_ff < CW'(MAX_POINTS)) begin
                        swr_en    = 1'b1;
                        scount_in = scount_ff + CW'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  pct_pkg::FN_RUN_TEST: begin
                     hit_in  = 1'b0;
                     base_in = '0;
                     cnt_in  = '0;
                     // a polyline of fewer than two points has no segments
                     if (fcount_ff < CW'(2) || scount_ff < CW'(2)) begin
                        state_in = pct_pkg::ST_DONE;
                     end else begin
                        state_in = pct_pkg::ST_LOAD;
                     end
                  end
                  pct_pkg::FN_CLEAR: begin
                     fcount_in   = '0;
                     scount_in   = '0;
                     overflow_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pct_pkg::ST_LOAD: begin
            // read points base..base+NUM_CELLS; each after the first closes a segment
            if (ld_idx < XW'(MAX_POINTS)) begin
               frd_addr = ld_idx[AW-1:0];
            end
            ld_vld_in   = 1'b1;
            ld_first_in = (cnt_ff == '0);
            ld_act_in   = (ld_idx < XW'(fcount_ff));
            if (cnt_ff == NW'(NUM_CELLS)) begin
               cnt_in   = '0;
               state_in = pct_pkg::ST_STREAM;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         pct_pkg::ST_STREAM: begin
            if (XW'(cnt_ff) < XW'(scount_ff)) begin
               srd_addr    = cnt_ff[AW-1:0];
               st_vld_in   = 1'b1;
               st_first_in = (cnt_ff == '0);
               cnt_in      = cnt_ff + NW'(1);
            end else begin
               cnt_in   = '0;
               state_in = pct_pkg::ST_DRAIN;
            end
         end
         pct_pkg::ST_DRAIN: begin
            // let the last streamed segment clear the row before reloading
            if (cnt_ff == NW'(DRAIN_CYCLES - 1)) begin
               cnt_in = '0;
               if (next_base + XW'(1) < XW'(fcount_ff)) begin
                  base_in  = next_base;
                  state_in = pct_pkg::ST_LOAD;
               end else begin
                  state_in = pct_pkg::ST_DONE;
               end
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         pct_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_drop_in  = overflow_ff;
               state_in     = pct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pct_pkg::ST_IDLE;
         cnt_ff       <= '0;
         base_ff      <= '0;
         hit_ff       <= 1'b0;
         fcount_ff    <= '0;
         scount_ff    <= '0;
         overflow_ff  <= 1'b0;
         ld_vld_ff    <= 1'b0;
         ld_first_ff  <= 1'b0;
         ld_act_ff    <= 1'b0;
         st_vld_ff    <= 1'b0;
         st_first_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         hit_ff       <= hit_in;
         fcount_ff    <= fcount_in;
         scount_ff    <= scount_in;
         overflow_ff  <= overflow_in;
         ld_vld_ff    <= ld_vld_in;
         ld_first_ff  <= ld_first_in;
         ld_act_ff    <= ld_act_in;
         st_vld_ff    <= st_vld_in;
         st_first_ff  <= st_first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_drop_ff <= rsp_drop_in;
      if (ld_vld_ff) begin
         fprev_ff <= frd_ff;
      end
      if (st_vld_ff) begin
         sprev_ff <= srd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fwr_en) begin
         first_mem[fcount_ff[AW-1:0]] <= {req_point_x, req_point_y};
      end
      frd_ff <= first_mem[frd_addr];
   end

   always_ff @(posedge clock) begin
      if (swr_en) begin
         second_mem[scount_ff[AW-1:0]] <= {req_point_x, req_point_y};
      end
      srd_ff <= second_mem[srd_addr];
   end

   assign chain_ld_ctl.shift  = ld_vld_ff && !ld_first_ff;
   assign chain_ld_ctl.active = ld_act_ff;
   assign chain_st_valid      = st_vld_ff && !st_first_ff;

   pct_chain #(
      .NUM_CELLS  (NUM_CELLS),
      .COORD_BITS (COORD_BITS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ld_ctl   (chain_ld_ctl),
      .ld_seg   ({fprev_ff, frd_ff}),
      .st_valid (chain_st_valid),
      .st_seg   ({sprev_ff, srd_ff}),
      .hit      (chain_hit)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_crossing_found = rsp_hit_ff;
   assign rsp_points_dropped = rsp_drop_ff;

   a_fcount_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= CW'(MAX_POINTS) && scount_ff <= CW'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pct_pkg::ST_DONE))
      else $error("response raised outside completion");

   a_tags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ld_vld_ff && st_vld_ff))
      else $error("load and stream reads overlap");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_func == pct_pkg::FN_CLEAR
      |=> fcount_ff == '0 && scount_ff == '0 && !overflow_ff)
      else $error("clear left state behind");

   a_row_idle_at_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == pct_pkg::ST_DONE |-> !chain_hit)
      else $error("cell row still busy at completion");

endmodule

// ----- hw/rtl/pct_cell.sv -----
module pct_cell #(
   parameter int unsigned COORD_BITS = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pct_pkg::load_ctl_type       ld_ctl_in,
   input  logic [4*COORD_BITS-1:0]     ld_seg_in,
   output logic                        ld_act_out,
   output logic [4*COORD_BITS-1:0]     ld_seg_out,
   input  logic                        st_vld_in,
   input  logic [4*COORD_BITS-1:0]     st_seg_in,
   output logic                        st_vld_out,
   output logic [4*COORD_BITS-1:0]     st_seg_out,
   output logic                        hit
);

   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned VW = PW + 1;

   logic                      act_ff;
   logic [4*COORD_BITS-1:0]   own_ff;
   logic                      vld_ff;
   logic [4*COORD_BITS-1:0]   seg_ff;
   logic                      pvld_ff;
   logic                      pvld_in;
   logic signed [PW-1:0]      prod_a_ff [4];
   logic signed [PW-1:0]      prod_b_ff [4];
   logic signed [PW-1:0]      prod_a_in [4];
   logic signed [PW-1:0]      prod_b_in [4];
   logic                      hit_ff;
   logic                      hit_in;

   logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry, sx, sy;
   logic signed [COORD_BITS-1:0] oa_x [4];
   logic signed [COORD_BITS-1:0] oa_y [4];
   logic signed [COORD_BITS-1:0] ob_x [4];
   logic signed [COORD_BITS-1:0] ob_y [4];
   logic signed [COORD_BITS-1:0] oc_x [4];
   logic signed [COORD_BITS-1:0] oc_y [4];
   logic signed [DW-1:0]         d_x1 [4];
   logic signed [DW-1:0]         d_y1 [4];
   logic signed [DW-1:0]         d_x2 [4];
   logic signed [DW-1:0]         d_y2 [4];
   logic signed [VW-1:0]         cross_v [4];
   logic [3:0]                   pos;
   logic [3:0]                   neg;

   assign {px, py, qx, qy} = own_ff;
   assign {rx, ry, sx, sy} = seg_ff;

   // orientations: (r,s,p), (r,s,q), (p,q,r), (p,q,s)
   assign oa_x = '{rx, rx, px, px};
   assign oa_y = '{ry, ry, py, py};
   assign ob_x = '{sx, sx, qx, qx};
   assign ob_y = '{sy, sy, qy, qy};
   assign oc_x = '{px, qx, rx, sx};
   assign oc_y = '{py, qy, ry, sy};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         d_x1[k]      = DW'(oc_x[k]) - DW'(oa_x[k]);
         d_y1[k]      = DW'(oc_y[k]) - DW'(oa_y[k]);
         d_x2[k]      = DW'(ob_x[k]) - DW'(oa_x[k]);
         d_y2[k]      = DW'(ob_y[k]) - DW'(oa_y[k]);
         prod_a_in[k] = d_x1[k] * d_y2[k];
         prod_b_in[k] = d_x2[k] * d_y1[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cross_v[k] = VW'(prod_a_ff[k]) - VW'(prod_b_ff[k]);
         neg[k]     = cross_v[k][VW-1];
         pos[k]     = !cross_v[k][VW-1] && (|cross_v[k]);
      end
      pvld_in = vld_ff && act_ff;
      // strict straddle both ways; any zero sign drops the pair
      hit_in  = pvld_ff
                && ((pos[0] && neg[1]) || (neg[0] && pos[1]))
                && ((pos[2] && neg[3]) || (neg[2] && pos[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         vld_ff  <= 1'b0;
         pvld_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         if (ld_ctl_in.shift) begin
            act_ff <= ld_ctl_in.active;
         end
         vld_ff  <= st_vld_in;
         pvld_ff <= pvld_in;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_ctl_in.shift) begin
         own_ff <= ld_seg_in;
      end
      seg_ff    <= st_seg_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   assign ld_act_out = act_ff;
   assign ld_seg_out = own_ff;
   assign st_vld_out = vld_ff;
   assign st_seg_out = seg_ff;
   assign hit        = hit_ff;

endmodule

// ----- hw/rtl/pct_chain.sv -----
module pct_chain #(
   parameter int unsigned NUM_CELLS  = 8,
   parameter int unsigned COORD_BITS = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pct_pkg::load_ctl_type       ld_ctl,
   input  logic [4*COORD_BITS-1:0]     ld_seg,
   input  logic                        st_valid,
   input  logic [4*COORD_BITS-1:0]     st_seg,
   output logic                        hit
);

   localparam int unsigned SEGW = 4 * COORD_BITS;

   logic                 act_chain [NUM_CELLS];
   logic [SEGW-1:0]      own_chain [NUM_CELLS];
   logic                 vld_chain [NUM_CELLS];
   logic [SEGW-1:0]      seg_chain [NUM_CELLS];
   logic [NUM_CELLS-1:0] hit_vec;

   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      pct_pkg::load_ctl_type ctl;
      logic [SEGW-1:0]       ld_seg_j;
      logic                  st_vld_j;
      logic [SEGW-1:0]       st_seg_j;

      if (j == 0) begin : g_head
         assign ctl      = ld_ctl;
         assign ld_seg_j = ld_seg;
         assign st_vld_j = st_valid;
         assign st_seg_j = st_seg;
      end else begin : g_body
         assign ctl.shift  = ld_ctl.shift;
         assign ctl.active = act_chain[j-1];
         assign ld_seg_j   = own_chain[j-1];
         assign st_vld_j   = vld_chain[j-1];
         assign st_seg_j   = seg_chain[j-1];
      end

      pct_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ld_ctl_in  (ctl),
         .ld_seg_in  (ld_seg_j),
         .ld_act_out (act_chain[j]),
         .ld_seg_out (own_chain[j]),
         .st_vld_in  (st_vld_j),
         .st_seg_in  (st_seg_j),
         .st_vld_out (vld_chain[j]),
         .st_seg_out (seg_chain[j]),
         .hit        (hit_vec[j])
      );
   end

   assign hit = |hit_vec;

endmodule
